FILE: rtl/mm4_pkg.sv
// Shared constants, codes and interface structs for the 4x4 matrix multiplier.
`default_nettype none
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;
  localparam int DIM_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int LA_W      = ADDR_W + 1;       // bank bit on top of element address
  localparam int LDEPTH    = 2 ** LA_W;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + DIM_W;   // exact sum of DIM products
  localparam int IDX_W     = 4;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_MULT     = 2'd2
  } op_t;

  typedef struct packed {
    logic              en;
    logic [LA_W-1:0]   laddr;
    logic [ADDR_W-1:0] raddr;
  } rd_req_t;

  typedef struct packed {
    logic                     en;
    logic                     to_left;
    logic [LA_W-1:0]          addr;
    logic signed [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              vld;
    logic              first;   // first product of an element
    logic              last;    // last product of an element
    logic              fin;     // belongs to the final element of the run
    logic [ADDR_W-1:0] idx;
  } mac_ctl_t;

  typedef struct packed {
    logic                     vld;
    logic                     fin;
    logic [ADDR_W-1:0]        idx;
    logic signed [DATA_W-1:0] data;
  } mac_res_t;

endpackage
`default_nettype wire

FILE: rtl/mm4_store.sv
// Left (two banks) and right matrix memories with per-entry valid bits.
`default_nettype none
module mm4_store (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mm4_pkg::rd_req_t                 rd,
  input  wire mm4_pkg::wr_req_t                 wr,
  output logic signed [mm4_pkg::DATA_W-1:0]     l_val,
  output logic signed [mm4_pkg::DATA_W-1:0]     r_val
);
  import mm4_pkg::*;

  logic signed [DATA_W-1:0] lmem [LDEPTH];
  logic signed [DATA_W-1:0] rmem [CELLS];
  logic [LDEPTH-1:0]        lvld_r;
  logic [CELLS-1:0]         rvld_r;
  logic signed [DATA_W-1:0] ldata_r;
  logic signed [DATA_W-1:0] rdata_r;
  logic                     lhit_r;
  logic                     rhit_r;

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvld_r <= '0;
      rvld_r <= '0;
    end else if (wr.en) begin
      if (wr.to_left) begin
        lvld_r[wr.addr] <= 1'b1;
      end else begin
        rvld_r[wr.addr[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.to_left) begin
        lmem[wr.addr] <= wr.data;
      end else begin
        rmem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      ldata_r <= lmem[rd.laddr];
      lhit_r  <= lvld_r[rd.laddr];
      rdata_r <= rmem[rd.raddr];
      rhit_r  <= rvld_r[rd.raddr];
    end
  end

  assign l_val = lhit_r ? ldata_r : '0;
  assign r_val = rhit_r ? rdata_r : '0;

endmodule
`default_nettype wire

FILE: rtl/mm4_mac.sv
// Multiply-accumulate pipeline: product register, exact accumulator, scale and saturate.
`default_nettype none
module mm4_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             adv,
  input  wire mm4_pkg::mac_ctl_t                ctl_in,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] l_val,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] r_val,
  output mm4_pkg::mac_res_t                     res
);
  import mm4_pkg::*;

  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-DATA_W:0]     upper;
  mac_ctl_t                  ctl_p_r;
  mac_ctl_t                  ctl_a_r;

  assign prod_nxt = l_val * r_val;
  assign acc_nxt  = ctl_p_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
      ctl_a_r <= '0;
    end else if (adv) begin
      ctl_p_r <= ctl_in;
      ctl_a_r <= ctl_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      if (ctl_p_r.vld) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // floor shift, then clamp to signed 32 bits
  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_W-1];

  always_comb begin
    res.vld = ctl_a_r.vld && ctl_a_r.last;
    res.fin = ctl_a_r.fin;
    res.idx = ctl_a_r.idx;
    if (~|upper || &upper) begin
      res.data = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res.data = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res.data = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/matrix4_multiply_in_place.sv
// Top level: chained 4x4 Q16.16 matrix multiply, result replaces the left matrix.
//
//  channel | dir | tdata (low bit up)                   | tuser  | tlast
//  --------+-----+--------------------------------------+--------+-------------------
//  in_     | in  | elem_index[3:0], elem_value[35:4]    | op     | -
//  out_    | out | out_index[3:0], out_value[35:4]      | -      | last product item
//
// Loads are taken only in idle. A multiply issues DIM reads per product element on
// the single read port of each matrix memory and feeds the one shared multiplier;
// no new item is taken until the run has drained and the banks have swapped.
// The product goes into the spare left bank and the banks swap at the end of the run.
// Reset clears only valid bits, so both matrices read as zero with no clearing pass.
// A stalled output register freezes the whole read/multiply/accumulate pipeline.
`default_nettype none
module matrix4_multiply_in_place (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // elem_index[3:0], elem_value[35:4], zero pad
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // out_index[3:0], out_value[35:4], zero pad
  output logic             out_tlast
);
  import mm4_pkg::*;

  localparam int TDATA_W = 40;
  localparam int PAD_W   = TDATA_W - IDX_W - DATA_W;
  localparam logic [ADDR_W-1:0] DIM_A    = ADDR_W'(DIM);
  localparam logic [DIM_W-1:0]  DIM_LAST = DIM_W'(DIM - 1);
  localparam logic [ADDR_W-1:0] K_LAST   = ADDR_W'(CELLS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t                   state_r, state_nxt;
  logic [DIM_W-1:0]         row_r, row_nxt;
  logic [DIM_W-1:0]         col_r, col_nxt;
  logic [DIM_W-1:0]         e_r, e_nxt;
  logic [ADDR_W-1:0]        k_r, k_nxt;
  logic                     bank_r, bank_nxt;
  mac_ctl_t                 ctl_s_r, ctl_s_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     adv;
  logic                     issue;
  logic                     in_accept;
  logic [IDX_W-1:0]         in_idx;
  logic signed [DATA_W-1:0] in_val;
  logic                     idx_ok;
  rd_req_t                  rd;
  wr_req_t                  wr;
  logic signed [DATA_W-1:0] l_val;
  logic signed [DATA_W-1:0] r_val;
  mac_res_t                 res;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_val    = in_tdata[IDX_W +: DATA_W];
  assign idx_ok    = int'(in_idx) < CELLS;
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // whole pipeline moves unless a result waits on a stalled output
  assign adv   = !out_valid_r || out_tready;
  assign issue = (state_r == ST_RUN) && adv;

  always_comb begin
    rd.en    = adv;
    rd.laddr = {bank_r, ADDR_W'(row_r) + DIM_A * ADDR_W'(e_r)};
    rd.raddr = ADDR_W'(e_r) + DIM_A * ADDR_W'(col_r);
  end

  // loads only in idle, product writes only during a run: one write port
  always_comb begin
    if (state_r == ST_IDLE) begin
      wr.en      = in_accept && idx_ok &&
                   (in_tuser == OP_WR_LEFT || in_tuser == OP_WR_RIGHT);
      wr.to_left = (in_tuser == OP_WR_LEFT);
      wr.addr    = {bank_r, ADDR_W'(in_idx)};
      wr.data    = in_val;
    end else begin
      wr.en      = adv && res.vld;
      wr.to_left = 1'b1;
      wr.addr    = {~bank_r, res.idx};
      wr.data    = res.data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    bank_nxt      = bank_r;
    ctl_s_nxt     = ctl_s_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    if (adv) begin
      ctl_s_nxt.vld   = issue;
      ctl_s_nxt.first = (e_r == '0);
      ctl_s_nxt.last  = (e_r == DIM_LAST);
      ctl_s_nxt.fin   = (k_r == K_LAST);
      ctl_s_nxt.idx   = k_r;
      out_valid_nxt   = res.vld;
      out_idx_nxt     = IDX_W'(res.idx);
      out_val_nxt     = res.data;
      out_last_nxt    = res.fin;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_tuser == OP_MULT) begin
          row_nxt   = '0;
          col_nxt   = '0;
          e_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (e_r == DIM_LAST) begin
            e_nxt = '0;
            k_nxt = k_r + ADDR_W'(1);
            if (row_r == DIM_LAST) begin
              row_nxt = '0;
              if (col_r == DIM_LAST) begin
                col_nxt   = '0;
                state_nxt = ST_DRAIN;
              end else begin
                col_nxt = col_r + DIM_W'(1);
              end
            end else begin
              row_nxt = row_r + DIM_W'(1);
            end
          end else begin
            e_nxt = e_r + DIM_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        // last product written to the spare bank: it becomes the left matrix
        if (adv && res.vld && res.fin) begin
          bank_nxt  = ~bank_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      ctl_s_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      ctl_s_r     <= ctl_s_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    e_r        <= e_nxt;
    k_r        <= k_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  mm4_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rd),
    .wr    (wr),
    .l_val (l_val),
    .r_val (r_val)
  );

  mm4_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_in (ctl_s_r),
    .l_val  (l_val),
    .r_val  (r_val),
    .res    (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: dv/tb_matrix4_multiply_in_place.sv
// Testbench for the chained 4x4 Q16.16 matrix multiplier: directed table, random items, scoreboard.
`timescale 1ns / 100ps
module tb_matrix4_multiply_in_place;
  import mm4_pkg::*;

  // op code that the block must ignore
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int RANDOM_ITEMS = 190;
  localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 100;    // extra wait after the last expected product

  localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

  // one product element as it leaves the block
  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } product_t;

  // directed stimulus row; when fixed is set, every product of a multiply is fixed_val
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    bit                fixed;
    logic [DATA_W-1:0] fixed_val;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 21;

  // Left column 0 and right row 0 carry the whole product, so each stage saturates
  // all 16 elements the same way; the product then becomes the next left matrix.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_MULT,     4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},  // zeros after reset
    '{OP_WR_LEFT,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_LEFT,  4'd1,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_LEFT,  4'd2,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_LEFT,  4'd3,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd4,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd8,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd12, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_MULT,     4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF},  // positive overflow
    '{OP_WR_RIGHT, 4'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd4,  32'h8000_0000, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd8,  32'h8000_0000, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd12, 32'h8000_0000, 1'b0, 32'h0},
    '{OP_MULT,     4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000},  // negative overflow
    '{OP_NOP,      4'd0,  32'h1234_5678, 1'b0, 32'h0},          // unused op, no effect
    '{OP_MULT,     4'd15, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},  // min*min, fields ignored
    '{OP_WR_LEFT,  4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_WR_RIGHT, 4'd15, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_MULT,     4'd7,  32'h5A5A_A5A5, 1'b0, 32'h0},
    '{OP_NOP,      4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [39:0]       in_tdata   = '0;   // elem_index[3:0], elem_value[35:4], zero pad
  logic [1:0]        in_tuser   = '0;   // op[1:0]
  logic              out_tready = 1'b0;
  wire logic         in_tready;
  wire logic         out_tvalid;
  wire logic [39:0]  out_tdata;         // out_index[3:0], out_value[35:4], zero pad
  wire logic         out_tlast;

  // mirror of the two matrix stores
  logic signed [DATA_W-1:0] left_mat  [CELLS];
  logic signed [DATA_W-1:0] right_mat [CELLS];

  product_t pending_products [$];
  product_t want_product;

  bit quiet       = 1'b0;   // set for a stretch with no gaps or stalls on either side
  int stall_left  = 0;
  int error_count = 0;
  int items_sent  = 0;
  int mult_count  = 0;
  int products_seen = 0;

  always #1 clk = ~clk;

  matrix4_multiply_in_place u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // element values: small fractions, full range, corner values, mid-size
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] corners [6];
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                32'h0000_0000, 32'h0001_0000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;   // within +-2.0
      4, 5, 6:    return $urandom;
      7:          return corners[3'($urandom_range(0, 5))];
      default:    return $urandom_range(0, 32'h3FF_FFFF) - 32'h200_0000; // within +-512
    endcase
  endfunction

  // Update the mirrored matrices for one accepted item and queue the products it causes.
  // All sums come from the old left matrix; the product then replaces it.
  task automatic track_matrices(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] val, input bit fixed,
                                input logic [DATA_W-1:0] fixed_val);
    logic signed [DATA_W-1:0] prod_mat [CELLS];
    logic signed [PROD_W-1:0] term;
    logic signed [67:0]       acc;
    logic signed [67:0]       scaled;
    product_t                 p;
    case (op)
      OP_WR_LEFT:  left_mat[idx]  = val;
      OP_WR_RIGHT: right_mat[idx] = val;
      OP_MULT: begin
        mult_count++;
        for (int c = 0; c < DIM; c++) begin
          for (int r = 0; r < DIM; r++) begin
            acc = '0;
            for (int e = 0; e < DIM; e++) begin
              term = left_mat[r + DIM * e] * right_mat[e + DIM * c];
              acc  = acc + term;
            end
            scaled = acc >>> FRAC_BITS;   // floor
            if (scaled > SAT_HI)      prod_mat[r + DIM * c] = 32'h7FFF_FFFF;
            else if (scaled < SAT_LO) prod_mat[r + DIM * c] = 32'h8000_0000;
            else                      prod_mat[r + DIM * c] = scaled[DATA_W-1:0];
          end
        end
        for (int k = 0; k < CELLS; k++) begin
          left_mat[k] = prod_mat[k];
          p.index = k[IDX_W-1:0];
          p.value = fixed ? fixed_val : prod_mat[k];
          p.last  = (k == CELLS - 1);
          pending_products.push_back(p);
        end
      end
      default: ;   // unused op
    endcase
  endtask

  // Present one item after a random gap and hold it until the block takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input bit fixed,
                           input logic [DATA_W-1:0] fixed_val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    track_matrices(op, idx, val, fixed, fixed_val);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
    end
  end

  // scoreboard: each accepted product against the oldest one queued
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      products_seen++;
      if (pending_products.size() == 0) begin
        $error("unexpected product item: out_index %0d out_value %h",
               out_tdata[3:0], out_tdata[35:4]);
        error_count++;
      end else begin
        want_product = pending_products.pop_front();
        if (out_tdata[3:0] !== want_product.index) begin
          $error("out_index: expected %0d, actual %0d", want_product.index, out_tdata[3:0]);
          error_count++;
        end
        if (out_tdata[35:4] !== want_product.value) begin
          $error("out_value (index %0d): expected %h, actual %h",
                 want_product.index, want_product.value, out_tdata[35:4]);
          error_count++;
        end
        if (out_tlast !== want_product.last) begin
          $error("out_last (index %0d): expected %b, actual %b",
                 want_product.index, want_product.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("matrix4_multiply_in_place verification failed");
    $finish;
  end

  initial begin : stimulus
    int r;
    logic [OP_W-1:0] op;
    for (int k = 0; k < CELLS; k++) begin
      left_mat[k]  = '0;
      right_mat[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].fixed, directed_rows[i].fixed_val);
    end

    // mostly loads with a multiply now and then; back to back multiplies chain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 80 && n < 120);
      r = $urandom_range(0, 99);
      if (r < 9)       op = OP_MULT;
      else if (r < 13) op = OP_NOP;
      else if (r < 57) op = OP_WR_LEFT;
      else             op = OP_WR_RIGHT;
      send_item(op, IDX_W'($urandom_range(0, 15)), pick_value(), 1'b0, '0);
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items including %0d multiplies", items_sent, mult_count);
    $display("%0d product items compared, %0d mismatches", products_seen, error_count);
    if (error_count == 0) begin
      $display("matrix4_multiply_in_place verification clean");
    end else begin
      $display("matrix4_multiply_in_place verification failed");
    end
    $finish;
  end

endmodule
